@@ rtl/bfr_pkg.sv @@
// Shared types and constants for the bitcoded field reader.
package bfr_pkg;

  localparam int unsigned STORE_BYTES_DEF = 4096;
  localparam int unsigned MCHAR_MAX_DEF   = 8;

  localparam logic [63:0] ONE_PATTERN  = 64'h3FF0_0000_0000_0000;
  localparam logic [63:0] BS_CONST_VAL = 64'd256;

  typedef enum logic [3:0] {
    OP_APPEND    = 4'd0,
    OP_CLEAR     = 4'd1,
    OP_SETPOS    = 4'd2,
    OP_SKIP      = 4'd3,
    OP_BITS      = 4'd4,
    OP_WORD      = 4'd5,
    OP_BITSHORT  = 4'd6,
    OP_BITLONG   = 4'd7,
    OP_BITDOUBLE = 4'd8,
    OP_DEFDOUBLE = 4'd9,
    OP_MCHAR     = 4'd10,
    OP_MSHORT    = 4'd11,
    OP_QUERY     = 4'd12
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CODE_WORD  = 2'd0,
    CODE_BYTE  = 2'd1,
    CODE_ALT   = 2'd2,
    CODE_FIXED = 2'd3
  } code_e;

  typedef enum logic [1:0] {
    SQ_IDLE,
    SQ_FETCH,
    SQ_SECOND,
    SQ_MERGE
  } sq_state_e;

endpackage

@@ rtl/bfr_mem.sv @@
// Byte store: one write port, one registered read port.
module bfr_mem #(
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [7:0]               wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [7:0]               rdata_o
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/bfr_shifter.sv @@
// Shared bit extractor: up to 8 MSB-first bits from a two-byte window.
module bfr_shifter (
  input  logic [7:0] b0_i,
  input  logic [7:0] b1_i,
  input  logic [2:0] offset_i,
  input  logic [3:0] count_i,
  output logic [7:0] bits_o
);

  logic [15:0] win;
  logic [3:0]  rsh;

  always_comb begin
    win    = {b0_i, b1_i} << offset_i;
    rsh    = 4'd8 - count_i;
    bits_o = win[15:8] >> rsh;
  end

endmodule

@@ rtl/dwg_bitcoded_field_reader_top.sv @@
// Bitcoded field reader: byte store, bit cursor and field sequencer.
// Append, clear, set, skip, query and zero-length reads raise out_valid_o in the cycle after acceptance.
// Other reads go chunk by chunk: bitcoded fields read the code, then one chunk per byte.
// Each chunk passes FETCH, SECOND and MERGE through the single store read port and shared extractor.
// One beat in flight at a time; input stalls while a field is being read or a result is held by out_stall_i.
// Reset clears length, position and control; store contents stay undefined.
module dwg_bitcoded_field_reader_top
  import bfr_pkg::*;
#(
  parameter int unsigned STORE_BYTES     = STORE_BYTES_DEF,
  parameter int unsigned MAX_MCHAR_BYTES = MCHAR_MAX_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [3:0]  op_i,
  input  logic [7:0]  data_byte_i,
  input  logic [15:0] bit_count_i,
  input  logic [63:0] default_bits_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] value_o,
  output logic [1:0]  status_o,
  output logic [15:0] position_o,
  output logic        more_available_o
);

  localparam int unsigned AW    = $clog2(STORE_BYTES);
  localparam int unsigned LEN_W = AW + 1;
  localparam int unsigned POS_W = LEN_W + 3;
  localparam int unsigned CMP_W = ((POS_W > 16) ? POS_W : 16) + 1;

  sq_state_e         state_q, state_d;
  op_e               op_q, op_d;
  logic [POS_W-1:0]  cur_q, cur_d;
  logic [3:0]        n_q, n_d;
  logic [3:0]        nbytes_q, nbytes_d;
  logic [3:0]        bi_q, bi_d;
  logic              code_ph_q, code_ph_d;
  logic [63:0]       acc_q, acc_d;
  logic [63:0]       defv_q, defv_d;
  logic [7:0]        b0_q, b0_d;
  logic [LEN_W-1:0]  len_q, len_d;
  logic [POS_W-1:0]  pos_q, pos_d;
  logic              out_valid_q, out_valid_d;
  logic [63:0]       value_q;
  status_e           status_q;
  logic [15:0]       position_q;
  logic              more_q;

  logic              accept;
  logic              fin;
  logic [63:0]       fin_value;
  status_e           fin_status;
  logic              mem_we;
  logic [AW-1:0]     raddr;
  logic [7:0]        rdata;
  logic [7:0]        bits;
  logic [POS_W-1:0]  limit;
  logic              chunk_fits;
  logic [CMP_W-1:0]  skip_sum;
  logic [CMP_W-1:0]  pos_ext;
  logic [AW-1:0]     cur_idx;
  logic [3:0]        nsel;
  logic [63:0]       acc_n;
  logic              more_chunks;

  assign limit      = {len_q, 3'b000};
  assign chunk_fits = ({1'b0, cur_q} + (POS_W+1)'(n_q)) <= {1'b0, limit};
  assign skip_sum   = CMP_W'(pos_q) + CMP_W'(bit_count_i);
  assign cur_idx    = cur_q[AW+2:3];
  assign raddr      = (state_q == SQ_SECOND) ? cur_idx + AW'(1) : cur_idx;
  assign in_stall_o = (state_q != SQ_IDLE) || (out_valid_q && out_stall_i);
  assign accept     = in_valid_i && !in_stall_o;

  bfr_mem #(.DEPTH(STORE_BYTES)) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (len_q[AW-1:0]),
    .wdata_i (data_byte_i),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  bfr_shifter u_shift (
    .b0_i     (b0_q),
    .b1_i     (rdata),
    .offset_i (cur_q[2:0]),
    .count_i  (n_q),
    .bits_o   (bits)
  );

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    cur_d       = cur_q;
    n_d         = n_q;
    nbytes_d    = nbytes_q;
    bi_d        = bi_q;
    code_ph_d   = code_ph_q;
    acc_d       = acc_q;
    defv_d      = defv_q;
    b0_d        = b0_q;
    len_d       = len_q;
    pos_d       = pos_q;
    fin         = 1'b0;
    fin_value   = '0;
    fin_status  = ST_OK;
    mem_we      = 1'b0;
    nsel        = (bit_count_i > 16'd8) ? 4'd8 : bit_count_i[3:0];
    acc_n       = acc_q;
    more_chunks = 1'b0;

    unique case (state_q)
      SQ_IDLE: begin
        if (accept) begin
          op_d      = op_e'(op_i);
          defv_d    = default_bits_i;
          cur_d     = pos_q;
          bi_d      = '0;
          acc_d     = '0;
          code_ph_d = 1'b0;
          n_d       = 4'd8;
          unique case (op_e'(op_i))
            OP_APPEND: begin
              fin = 1'b1;
              if (len_q < LEN_W'(STORE_BYTES)) begin
                mem_we = 1'b1;
                len_d  = len_q + LEN_W'(1);
              end else begin
                fin_status = ST_FULL;
              end
            end
            OP_CLEAR: begin
              fin   = 1'b1;
              len_d = '0;
              pos_d = '0;
            end
            OP_SETPOS: begin
              fin = 1'b1;
              if (CMP_W'(bit_count_i) <= CMP_W'(limit)) pos_d = POS_W'(bit_count_i);
              else fin_status = ST_RANGE;
            end
            OP_SKIP: begin
              fin = 1'b1;
              if (skip_sum <= CMP_W'(limit)) pos_d = POS_W'(skip_sum);
              else fin_status = ST_RANGE;
            end
            OP_BITS: begin
              if (nsel == 4'd0) begin
                fin = 1'b1;
              end else begin
                n_d     = nsel;
                state_d = SQ_FETCH;
              end
            end
            OP_WORD: begin
              nbytes_d = (bit_count_i <= 16'd16) ? 4'd2 :
                         (bit_count_i <= 16'd32) ? 4'd4 : 4'd8;
              state_d  = SQ_FETCH;
            end
            OP_BITSHORT, OP_BITLONG, OP_BITDOUBLE, OP_DEFDOUBLE: begin
              code_ph_d = 1'b1;
              n_d       = 4'd2;
              state_d   = SQ_FETCH;
            end
            OP_MCHAR: begin
              state_d = SQ_FETCH;
            end
            OP_MSHORT: begin
              nbytes_d = 4'd2;
              state_d  = SQ_FETCH;
            end
            default: begin
              fin = 1'b1;
            end
          endcase
        end
      end
      SQ_FETCH: begin
        if (chunk_fits) begin
          state_d = SQ_SECOND;
        end else begin
          fin        = 1'b1;
          fin_status = ST_RANGE;
          state_d    = SQ_IDLE;
        end
      end
      SQ_SECOND: begin
        b0_d    = rdata;
        state_d = SQ_MERGE;
      end
      SQ_MERGE: begin
        cur_d = cur_q + POS_W'(n_q);
        if (op_q == OP_BITS) begin
          acc_n = 64'(bits);
        end else if (code_ph_q) begin
          code_ph_d = 1'b0;
          acc_n     = '0;
          nbytes_d  = 4'd0;
          unique case (op_q)
            OP_BITSHORT: begin
              if (bits[1:0] == CODE_WORD) nbytes_d = 4'd2;
              else if (bits[1:0] == CODE_BYTE) nbytes_d = 4'd1;
              else if (bits[1:0] == CODE_FIXED) acc_n = BS_CONST_VAL;
            end
            OP_BITLONG: begin
              if (bits[1:0] == CODE_WORD) nbytes_d = 4'd4;
              else if (bits[1:0] == CODE_BYTE) nbytes_d = 4'd1;
            end
            OP_BITDOUBLE: begin
              if (bits[1:0] == CODE_WORD) nbytes_d = 4'd8;
              else if (bits[1:0] == CODE_BYTE) acc_n = ONE_PATTERN;
            end
            default: begin
              acc_n = defv_q;
              if (bits[1:0] == CODE_BYTE) nbytes_d = 4'd4;
              else if (bits[1:0] == CODE_ALT) nbytes_d = 4'd6;
              else if (bits[1:0] == CODE_FIXED) nbytes_d = 4'd8;
            end
          endcase
          n_d         = 4'd8;
          bi_d        = '0;
          more_chunks = (nbytes_d != 4'd0);
        end else if (op_q == OP_MCHAR) begin
          acc_n       = acc_q | (64'(bits[6:0]) << (6'(bi_q) * 6'd7));
          bi_d        = bi_q + 4'd1;
          more_chunks = bits[7] && ((bi_q + 4'd1) < 4'(MAX_MCHAR_BYTES));
        end else begin
          acc_n[8*bi_q[2:0] +: 8] = bits;
          bi_d = bi_q + 4'd1;
          if (op_q == OP_MSHORT && bi_q == 4'd1 && bits[7]) nbytes_d = 4'd4;
          more_chunks = (bi_q + 4'd1) < nbytes_d;
        end
        acc_d = acc_n;
        if (more_chunks) begin
          state_d = SQ_FETCH;
        end else begin
          fin     = 1'b1;
          pos_d   = cur_d;
          state_d = SQ_IDLE;
          unique case (op_q)
            OP_MCHAR:  fin_value = {32'b0, acc_n[31:0]};
            OP_MSHORT: fin_value = {34'b0, acc_n[30:16], acc_n[14:0]};
            default:   fin_value = acc_n;
          endcase
        end
      end
      default: state_d = SQ_IDLE;
    endcase

    out_valid_d = fin || (out_valid_q && out_stall_i);
    pos_ext     = CMP_W'(pos_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SQ_IDLE;
      code_ph_q   <= 1'b0;
      len_q       <= '0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      code_ph_q   <= code_ph_d;
      len_q       <= len_d;
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    cur_q    <= cur_d;
    n_q      <= n_d;
    nbytes_q <= nbytes_d;
    bi_q     <= bi_d;
    acc_q    <= acc_d;
    defv_q   <= defv_d;
    b0_q     <= b0_d;
    if (fin) begin
      value_q    <= fin_value;
      status_q   <= fin_status;
      position_q <= pos_ext[15:0];
      more_q     <= pos_d < {len_d, 3'b000};
    end
  end

  assign out_valid_o      = out_valid_q;
  assign value_o          = value_q;
  assign status_o         = status_q;
  assign position_o       = position_q;
  assign more_available_o = more_q;

`ifndef NO_ASSERTIONS
  a_accept_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> state_q == SQ_IDLE)
    else $error("beat accepted while sequencer busy");

  a_len_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LEN_W'(STORE_BYTES))
    else $error("store length exceeds capacity");

  a_pos_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= limit)
    else $error("position beyond loaded data");

  a_range_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin && fin_status == ST_RANGE |-> fin_value == 64'd0 && pos_d == pos_q)
    else $error("failed read changed value or position");

  a_merge_order : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == SQ_MERGE |-> $past(state_q) == SQ_SECOND)
    else $error("merge without second byte fetch");
`endif

endmodule
